### rtl/trs_pkg.sv
package trs_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int POS_W = $clog2(BUFFER_BYTES + 1);
	localparam logic [POS_W-1:0] BUF_END = POS_W'(BUFFER_BYTES);

	localparam int FIFO_AW = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef enum logic [1:0] {
		CFG_SEARCHED_TYPE = 2'd0,
		CFG_COPY_ENABLE   = 2'd1,
		CFG_COPY_LIMIT    = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_TYPE   = 2'd0,
		PH_LEN_LO = 2'd1,
		PH_LEN_HI = 2'd2,
		PH_VALUE  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_FOUND     = 2'd1,
		KIND_NOT_FOUND = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  searched_type;
		logic        copy_enable;
		logic [15:0] copy_limit;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value_byte;
		logic [15:0] record_length;
		logic [12:0] value_offset;
		logic        done_res;
	} res_t;

	// Results produced by one input word, slot r0 first.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic [12:0] to_offset(input logic [POS_W-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[12:0];
	endfunction

endpackage

### rtl/trs_scan.sv
module trs_scan
	import trs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] data,
	input  logic       last,
	input  cfg_t       cfg,
	output push_t      push
);

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  position_q, position_d;
	logic [15:0]       remaining_q, remaining_d;
	logic [7:0]        length_low_q, length_low_d;
	logic              type_matched_q, type_matched_d;
	logic [15:0]       reported_length_q, reported_length_d;
	logic              decided_q, decided_d;
	logic [POS_W-1:0]  value_start_q, value_start_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_TYPE;
			position_q        <= '0;
			remaining_q       <= '0;
			length_low_q      <= '0;
			type_matched_q    <= 1'b0;
			reported_length_q <= '0;
			decided_q         <= 1'b0;
			value_start_q     <= '0;
		end else if (go) begin
			phase_q           <= phase_d;
			position_q        <= position_d;
			remaining_q       <= remaining_d;
			length_low_q      <= length_low_d;
			type_matched_q    <= type_matched_d;
			reported_length_q <= reported_length_d;
			decided_q         <= decided_d;
			value_start_q     <= value_start_d;
		end
	end

	always_comb begin
		res_t        r;
		logic [1:0]  n;
		logic [15:0] raw;
		logic [15:0] len;
		res_t        r0;
		res_t        r1;

		phase_d           = phase_q;
		position_d        = position_q;
		remaining_d       = remaining_q;
		length_low_d      = length_low_q;
		type_matched_d    = type_matched_q;
		reported_length_d = reported_length_q;
		decided_d         = decided_q;
		value_start_d     = value_start_q;
		n   = 2'd0;
		r0  = '0;
		r1  = '0;
		r   = '0;
		raw = {data, length_low_q};
		len = (cfg.copy_enable && raw > cfg.copy_limit) ? cfg.copy_limit : raw;

		if (!decided_q) begin
			if (position_q >= BUF_END) begin
				r = '0;
				r.done_res = 1'b1;
				if (phase_q == PH_VALUE && type_matched_q) begin
					r.kind          = KIND_FOUND;
					r.record_length = reported_length_q;
					r.value_offset  = to_offset(value_start_q);
				end else begin
					r.kind = KIND_NOT_FOUND;
				end
				r0 = r;
				n = 2'd1;
				decided_d = 1'b1;
			end else begin
				unique case (phase_q)
					PH_TYPE: begin
						type_matched_d = (data == cfg.searched_type);
						if (!type_matched_d && data == 8'd0) begin
							r = '0;
							r.kind = KIND_NOT_FOUND;
							r.done_res = 1'b1;
							r0 = r;
							n = 2'd1;
							decided_d = 1'b1;
						end else begin
							phase_d = PH_LEN_LO;
						end
					end
					PH_LEN_LO: begin
						length_low_d = data;
						phase_d = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						value_start_d = position_q + 1'b1;
						if (type_matched_q) begin
							reported_length_d = len;
							if (cfg.copy_enable && len != 16'd0) begin
								remaining_d = len;
								phase_d = PH_VALUE;
							end else begin
								r = '0;
								r.kind          = KIND_FOUND;
								r.record_length = len;
								r.value_offset  = to_offset(value_start_d);
								r.done_res      = 1'b1;
								r0 = r;
								n = 2'd1;
								decided_d = 1'b1;
							end
						end else if (raw == 16'd0) begin
							phase_d = PH_TYPE;
						end else begin
							remaining_d = raw;
							phase_d = PH_VALUE;
						end
					end
					PH_VALUE: begin
						if (remaining_q != 16'd0)
							remaining_d = remaining_q - 16'd1;
						if (type_matched_q) begin
							r = '0;
							r.kind = KIND_BYTE;
							r.value_byte = data;
							r0 = r;
							n = 2'd1;
							if (remaining_d == 16'd0) begin
								r = '0;
								r.kind          = KIND_FOUND;
								r.record_length = reported_length_q;
								r.value_offset  = to_offset(value_start_q);
								r.done_res      = 1'b1;
								r1 = r;
								n = 2'd2;
								decided_d = 1'b1;
							end
						end else if (remaining_d == 16'd0) begin
							phase_d = PH_TYPE;
						end
					end
					default: phase_d = PH_TYPE;
				endcase
				position_d = position_q + 1'b1;
			end
		end

		// Close an open search on the final byte, then clear the scan.
		if (last) begin
			if (!decided_d) begin
				r = '0;
				r.done_res = 1'b1;
				if (phase_d == PH_VALUE && type_matched_d) begin
					r.kind          = KIND_FOUND;
					r.record_length = reported_length_d;
					r.value_offset  = to_offset(value_start_d);
				end else begin
					r.kind = KIND_NOT_FOUND;
				end
				if (n == 2'd0)
					r0 = r;
				else
					r1 = r;
				n = n + 2'd1;
			end
			phase_d           = PH_TYPE;
			position_d        = '0;
			remaining_d       = '0;
			length_low_d      = '0;
			type_matched_d    = 1'b0;
			reported_length_d = '0;
			decided_d         = 1'b0;
			value_start_d     = '0;
		end

		push.n  = n;
		push.r0 = r0;
		push.r1 = r1;
	end

endmodule

### rtl/trs_out_fifo.sv
module trs_out_fifo
	import trs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  push_t push,
	output logic  space,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  head
);

	res_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   count_q;
	logic [1:0]         n_push;
	logic               pop;

	assign n_push    = go ? push.n : 2'd0;
	assign res_valid = (count_q != '0);
	assign pop       = res_valid && !res_stall;
	assign head      = mem_q[rp_q];
	// Room for the worst case of two results per word.
	assign space     = (count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (n_push == 2'd2)
			mem_q[wp_q + 1'b1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + FIFO_AW'(n_push);
			if (pop)
				rp_q <= rp_q + 1'b1;
			count_q <= count_q + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

### rtl/tlv_record_search.sv
// Scans a byte buffer of type-length-value records (type byte, 16-bit
// little-endian length, value) for the configured type and reports found or
// not found, optionally streaming the matched value bytes first. Takes one
// byte per cycle while byte_stall is low; a byte that yields two results
// (last copied byte plus status) is held in the four-entry result queue,
// which drains one word per cycle while res_stall is low. A result is
// presented once its byte has passed the input register and the scan into
// the queue. Write the registers only while no search result is pending.
module tlv_record_search
	import trs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [7:0]  value_byte,
	output logic [15:0] record_length,
	output logic [12:0] value_offset,
	output logic        done_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       space;
	logic       go;
	push_t      push;
	res_t       head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.searched_type <= 8'd0;
			cfg_q.copy_enable   <= 1'b1;
			cfg_q.copy_limit    <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SEARCHED_TYPE: cfg_q.searched_type <= cfg_data[7:0];
				CFG_COPY_ENABLE:   cfg_q.copy_enable   <= cfg_data[0];
				CFG_COPY_LIMIT:    cfg_q.copy_limit    <= cfg_data;
				default:           ;
			endcase
		end
	end

	assign go         = valid_s1 && space;
	assign byte_stall = valid_s1 && !space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!byte_stall)
			valid_s1 <= byte_valid;
	end

	// Hold the word while the result queue lacks room for two results.
	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	trs_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.data   (data_s1),
		.last   (last_s1),
		.cfg    (cfg_q),
		.push   (push)
	);

	trs_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.push      (push),
		.space     (space),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.head      (head)
	);

	assign kind          = head.kind;
	assign value_byte    = head.value_byte;
	assign record_length = head.record_length;
	assign value_offset  = head.value_offset;
	assign done_res      = head.done_res;

endmodule

### rtl/trs_checker.sv
module trs_checker
	import trs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  kind,
	input logic [7:0]  value_byte,
	input logic [15:0] record_length,
	input logic [12:0] value_offset,
	input logic        done_res
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_hold_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(kind) && $stable(record_length))
		else $error("stalled result changed");

	a_byte_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_BYTE |->
			!done_res && record_length == 16'd0 && value_offset == 13'd0)
		else $error("copied byte carries status fields");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_BYTE |->
			done_res && value_byte == 8'd0 && (kind == KIND_FOUND || kind == KIND_NOT_FOUND))
		else $error("malformed status result");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_NOT_FOUND |->
			record_length == 16'd0 && value_offset == 13'd0)
		else $error("not found carries length or offset");

endmodule

bind tlv_record_search trs_checker u_trs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.kind          (kind),
	.value_byte    (value_byte),
	.record_length (record_length),
	.value_offset  (value_offset),
	.done_res      (done_res)
);

### sim/tb_tlv_record_search.sv
module tb_tlv_record_search;
	import trs_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 80;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

	typedef struct packed {
		row_op_t     op;
		logic [7:0]  b;
		logic        l;
		logic        typed;
		kind_t       k;
		logic [15:0] len;
		logic [12:0] off;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  value_byte;
	logic [15:0] record_length;
	logic [12:0] value_offset;
	logic        done_res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	tlv_record_search u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.value_byte   (value_byte),
		.record_length(record_length),
		.value_offset (value_offset),
		.done_res     (done_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Scan state mirrored from the block
	cfg_t        cfg_shadow = '{8'h00, 1'b1, 16'hFFFF};
	phase_t      sc_phase = PH_TYPE;
	int unsigned sc_pos = 0;
	logic [15:0] sc_remain = '0;
	logic [7:0]  sc_len_lo = '0;
	logic        sc_match = 1'b0;
	logic [15:0] sc_report = '0;
	logic        sc_decided = 1'b0;
	int unsigned sc_start = 0;

	res_t step_out[$];
	res_t pending_res[$];

	logic cur_typed = 1'b0;
	res_t cur_exp = '0;
	logic calm = 1'b0;
	int   hold_req = 0;
	int   fail_count = 0;
	int   idle_run = 0;

	function automatic res_t mk_res(input kind_t k, input logic [7:0] vb,
			input logic [15:0] len, input logic [12:0] off);
		res_t r;
		r.kind = k;
		r.value_byte = vb;
		r.record_length = len;
		r.value_offset = off;
		r.done_res = (k != KIND_BYTE);
		return r;
	endfunction

	task automatic scan_clear();
		sc_phase = PH_TYPE;
		sc_pos = 0;
		sc_remain = '0;
		sc_len_lo = '0;
		sc_match = 1'b0;
		sc_report = '0;
		sc_decided = 1'b0;
		sc_start = 0;
	endtask

	task automatic close_search();
		if (sc_phase == PH_VALUE && sc_match)
			step_out.push_back(mk_res(KIND_FOUND, 8'h00, sc_report, 13'(sc_start)));
		else
			step_out.push_back(mk_res(KIND_NOT_FOUND, 8'h00, 16'h0, 13'h0));
		sc_decided = 1'b1;
	endtask

	task automatic scan_word(input logic [7:0] b, input logic l);
		logic [15:0] raw;
		logic [15:0] len;
		step_out.delete();
		if (!sc_decided) begin
			if (sc_pos >= BUFFER_BYTES) begin
				close_search();
			end else begin
				case (sc_phase)
					PH_TYPE: begin
						sc_match = (b == cfg_shadow.searched_type);
						if (!sc_match && b == 8'h00) begin
							step_out.push_back(mk_res(KIND_NOT_FOUND, 8'h00, 16'h0, 13'h0));
							sc_decided = 1'b1;
						end else begin
							sc_phase = PH_LEN_LO;
						end
					end
					PH_LEN_LO: begin
						sc_len_lo = b;
						sc_phase = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						raw = {b, sc_len_lo};
						sc_start = sc_pos + 1;
						if (sc_match) begin
							len = raw;
							if (cfg_shadow.copy_enable && len > cfg_shadow.copy_limit)
								len = cfg_shadow.copy_limit;
							sc_report = len;
							if (cfg_shadow.copy_enable && len != 16'h0) begin
								sc_remain = len;
								sc_phase = PH_VALUE;
							end else begin
								step_out.push_back(mk_res(KIND_FOUND, 8'h00, len, 13'(sc_start)));
								sc_decided = 1'b1;
							end
						end else if (raw == 16'h0) begin
							sc_phase = PH_TYPE;
						end else begin
							sc_remain = raw;
							sc_phase = PH_VALUE;
						end
					end
					default: begin
						if (sc_remain != 16'h0)
							sc_remain = sc_remain - 16'd1;
						if (sc_match) begin
							step_out.push_back(mk_res(KIND_BYTE, b, 16'h0, 13'h0));
							if (sc_remain == 16'h0) begin
								step_out.push_back(mk_res(KIND_FOUND, 8'h00, sc_report,
									13'(sc_start)));
								sc_decided = 1'b1;
							end
						end else if (sc_remain == 16'h0) begin
							sc_phase = PH_TYPE;
						end
					end
				endcase
				sc_pos++;
			end
		end
		if (l) begin
			if (!sc_decided)
				close_search();
			scan_clear();
		end
	endtask

	task automatic flag_result(input string why, input res_t e);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s: expected kind=%0d byte=%02h len=%0d off=%0d done=%0d",
				why, e.kind, e.value_byte, e.record_length, e.value_offset, e.done_res);
			$display("  actual kind=%0d byte=%02h len=%0d off=%0d done=%0d",
				kind, value_byte, record_length, value_offset, done_res);
		end
	endtask

	always @(posedge clk) begin
		logic busy;
		res_t e;
		busy = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				case (cfg_index)
					CFG_SEARCHED_TYPE: cfg_shadow.searched_type = cfg_data[7:0];
					CFG_COPY_ENABLE:   cfg_shadow.copy_enable = cfg_data[0];
					CFG_COPY_LIMIT:    cfg_shadow.copy_limit = cfg_data;
					default: ;
				endcase
			end
			if (byte_valid && !byte_stall) begin
				busy = 1'b1;
				scan_word(data_byte, last_byte);
				if (cur_typed)
					pending_res.push_back(cur_exp);
				else
					foreach (step_out[i]) pending_res.push_back(step_out[i]);
			end
			if (res_valid && !res_stall) begin
				busy = 1'b1;
				if (pending_res.size() == 0) begin
					flag_result("result with none pending", '0);
				end else begin
					e = pending_res.pop_front();
					if (kind !== e.kind || value_byte !== e.value_byte ||
							record_length !== e.record_length ||
							value_offset !== e.value_offset || done_res !== e.done_res)
						flag_result("result mismatch", e);
				end
			end
			idle_run = busy ? 0 : idle_run + 1;
		end
	end

	initial begin
		while (idle_run < IDLE_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random stall, no stall while calm, long hold on request
	always @(negedge clk) begin
		int hold_seen;
		int hold_left;
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			res_stall = 1'b1;
			hold_left--;
		end else begin
			res_stall = calm ? 1'b0 : ($urandom_range(0, 99) < 28);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic l, input logic typed,
			input res_t e);
		while (!calm && $urandom_range(0, 99) < 28) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		data_byte = b;
		last_byte = l;
		cur_typed = typed;
		cur_exp = e;
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		byte_valid = 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
	endtask

	// Drain, then let any word that yields nothing clear the pipeline
	task automatic settle();
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(CFG_SEARCHED_TYPE, 16'(c.searched_type));
		write_reg(CFG_COPY_ENABLE, 16'(c.copy_enable));
		write_reg(CFG_COPY_LIMIT, c.copy_limit);
	endtask

	// One buffer: mostly well-formed records, some noise, some cut or padded
	task automatic random_buffer(inout int items);
		logic [7:0] bytes_q[$];
		logic [7:0] typ;
		int r;
		int n;
		int len;
		int keep;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			n = $urandom_range(1, 12);
			repeat (n) bytes_q.push_back(8'($urandom));
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				r = $urandom_range(0, 99);
				typ = (r < 45) ? cfg_shadow.searched_type :
					(r < 60) ? 8'h00 : 8'($urandom);
				len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) :
					$urandom_range(7, 300);
				bytes_q.push_back(typ);
				bytes_q.push_back(len[7:0]);
				bytes_q.push_back(len[15:8]);
				repeat (len) bytes_q.push_back(8'($urandom));
			end
		end
		r = $urandom_range(0, 99);
		if (r < 15) begin
			keep = $urandom_range(1, bytes_q.size());
			while (bytes_q.size() > keep) void'(bytes_q.pop_back());
		end
		items += bytes_q.size();
		// trailing words are not counted; the block ignores them once it has decided
		if (r >= 15 && r < 30)
			repeat ($urandom_range(1, 4)) bytes_q.push_back(8'($urandom));
		foreach (bytes_q[i])
			send_word(bytes_q[i], i == bytes_q.size() - 1, 1'b0, '0);
	endtask

	function automatic row_t wd(input logic [7:0] b, input logic l);
		row_t r;
		r = '0;
		r.op = ROW_WORD;
		r.b = b;
		r.l = l;
		return r;
	endfunction

	function automatic row_t wx(input logic [7:0] b, input logic l, input kind_t k,
			input logic [15:0] len, input logic [12:0] off);
		row_t r;
		r = wd(b, l);
		r.typed = 1'b1;
		r.k = k;
		r.len = len;
		r.off = off;
		return r;
	endfunction

	function automatic row_t rg(input cfg_index_t idx, input logic [15:0] val);
		row_t r;
		r = '0;
		r.op = ROW_REG;
		r.b = 8'(idx);
		r.len = val;
		return r;
	endfunction

	initial begin
		row_t script[$];
		cfg_t plan[6];
		int items;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SEARCHED_TYPE;
		cfg_data = 16'h0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		script = '{
			// reset settings search type 0: empty match
			wd(8'h00, 1'b0), wd(8'h00, 1'b0),
			wx(8'h00, 1'b1, KIND_FOUND, 16'h0, 13'd3),
			rg(CFG_SEARCHED_TYPE, 16'h005A),
			// type 0 that does not match, then header cut off
			wx(8'h00, 1'b1, KIND_NOT_FOUND, 16'h0, 13'h0),
			wx(8'hFF, 1'b1, KIND_NOT_FOUND, 16'h0, 13'h0),
			wd(8'h5A, 1'b0), wd(8'h03, 1'b0), wd(8'h00, 1'b0),
			wd(8'h11, 1'b0), wd(8'h22, 1'b0), wd(8'h33, 1'b1),
			// skip an empty record, then hit type 0
			wd(8'h07, 1'b0), wd(8'h00, 1'b0), wd(8'h00, 1'b0),
			wx(8'h00, 1'b1, KIND_NOT_FOUND, 16'h0, 13'h0),
			// copy cut off by the last word
			wd(8'h5A, 1'b0), wd(8'hFF, 1'b0), wd(8'hFF, 1'b0),
			wd(8'hC3, 1'b0), wd(8'h3C, 1'b1),
			rg(CFG_COPY_ENABLE, 16'h0),
			wd(8'h5A, 1'b0), wd(8'h34, 1'b0),
			wx(8'h12, 1'b0, KIND_FOUND, 16'h1234, 13'd3),
			wd(8'h77, 1'b1),
			rg(CFG_COPY_ENABLE, 16'h1), rg(CFG_COPY_LIMIT, 16'h0),
			wd(8'h5A, 1'b0), wd(8'h05, 1'b0),
			wx(8'h00, 1'b1, KIND_FOUND, 16'h0, 13'd3)
		};
		foreach (script[i]) begin
			if (script[i].op == ROW_REG) begin
				settle();
				write_reg(cfg_index_t'(script[i].b[1:0]), script[i].len);
			end else begin
				send_word(script[i].b, script[i].l, script[i].typed,
					mk_res(script[i].k, 8'h00, script[i].len, script[i].off));
			end
		end

		plan[0] = '{8'h00, 1'b1, 16'h0000};
		plan[1] = '{8'hFF, 1'b0, 16'hFFFF};
		plan[2] = '{8'($urandom), 1'b1, 16'h0001};
		plan[3] = '{8'($urandom), 1'b1, 16'($urandom_range(0, 8))};
		plan[4] = '{8'($urandom), 1'b0, 16'($urandom)};
		plan[5] = '{8'($urandom), 1'b1, 16'hFFFF};

		for (int ph = 0; ph < 6; ph++) begin
			logic done_extra;
			settle();
			load_config(plan[ph]);
			calm = (ph == 2);
			items = 0;
			done_extra = 1'b0;
			while (items < PHASE_ITEMS) begin
				random_buffer(items);
				if (!done_extra && items > 40) begin
					done_extra = 1'b1;
					// phase 3 holds the receiver while words keep coming; phase 4 drains
					if (ph == 3)
						hold_req++;
					if (ph == 4)
						drain_results();
				end
			end
		end
		calm = 1'b0;
		settle();
		if (fail_count == 0 && pending_res.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
